// ===== hw/rtl/wtc_pkg.sv =====
// Shared types and constants for the waveform type classifier.
// No dependencies; every other file imports this package.
package wtc_pkg;

    localparam int SAMPLE_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CENTI_W    = 15;
    localparam int PCT_W      = 7;
    localparam int DUTY_W     = 11;

    // Root of a 2*CENTI_W bit radicand: one result bit per step.
    localparam int ROOT_STEPS = CENTI_W;
    localparam int RAD_W      = 2 * CENTI_W;
    localparam int REM_W      = CENTI_W + 2;

    localparam int MIN_PERIODS = 3;
    localparam int RATIO_MUL   = 20;   // 2000 per mille scale over centi counts
    localparam int PCT_FULL    = 100;

    typedef enum logic [2:0] {
        WAVE_DC       = 3'd0,
        WAVE_NOISE    = 3'd1,
        WAVE_PULSE    = 3'd2,
        WAVE_SQUARE   = 3'd3,
        WAVE_SAW      = 3'd4,
        WAVE_SINE     = 3'd5,
        WAVE_TRIANGLE = 3'd6,
        WAVE_RSVD     = 3'd7
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWING_FLOOR  = 3'd0,
        CFG_REGULAR_MIN  = 3'd1,
        CFG_TWO_LEVEL    = 3'd2,
        CFG_DUTY_LOW     = 3'd3,
        CFG_DUTY_HIGH    = 3'd4,
        CFG_SQUARE_MIN   = 3'd5,
        CFG_SINE_MIN     = 3'd6,
        CFG_SAW_BALANCE  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  swing_floor;
        logic [6:0]  regular_pct_min;
        logic [6:0]  two_level_pct_min;
        logic [9:0]  duty_low_permille;
        logic [9:0]  duty_high_permille;
        logic [10:0] square_ratio_min;
        logic [10:0] sine_ratio_min;
        logic [6:0]  saw_balance_pct;
    } t_cfg;

    // Decision flags carried down the pipeline next to the root.
    typedef struct packed {
        logic  early;   // type settled before the ratio test
        logic  saw;     // slope balance says sawtooth
        t_wave etype;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ===== hw/rtl/waveform_type_classifier.sv =====
// Waveform type classifier top level: configuration registers and pipeline.
// Depends on wtc_pkg, wtc_front, wtc_root and wtc_back.
//
//   Channel   Handshake               Transfer when          Payload
//   input     i_valid / o_stall       i_valid && !o_stall    measurement record fields
//   output    o_valid / i_stall       o_valid && !i_stall    o_signal_type
//   config    i_cfg_we                i_cfg_we               i_cfg_idx, i_cfg_data
//
// One record per cycle sustained while i_stall is low, through 3 front stages,
// 15 root stages (one bit of the AC RMS square root each) and 2 back stages.
// Reset clears all stage valid bits and loads the threshold registers with
// their defaults. Each stage holds its item only while the next one is full and
// stalled, so bubbles close up; intake stalls only once all 20 stages hold items.
module waveform_type_classifier
    import wtc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // measurement record
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SAMPLE_BITS-1:0]   i_top_level,
    input  logic [SAMPLE_BITS-1:0]   i_base_level,
    input  logic                     i_frequency_found,
    input  logic [COUNT_BITS-1:0]    i_period_count,
    input  logic [PCT_W-1:0]         i_regular_pct,
    input  logic [PCT_W-1:0]         i_two_level_pct,
    input  logic signed [DUTY_W-1:0] i_duty_permille,
    input  logic [CENTI_W-1:0]       i_rms_centi,
    input  logic [CENTI_W-1:0]       i_mean_centi,
    input  logic [COUNT_BITS-1:0]    i_rising_samples,
    input  logic [COUNT_BITS-1:0]    i_falling_samples,
    // result
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_signal_type
);

    localparam int SIDE_W = SAMPLE_BITS + FLAGS_W;

    t_cfg r_cfg;

    // Registers keep only their own width; every index is a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{swing_floor:        8'd6,
                       regular_pct_min:    7'd60,
                       two_level_pct_min:  7'd65,
                       duty_low_permille:  10'd400,
                       duty_high_permille: 10'd600,
                       square_ratio_min:   11'd850,
                       sine_ratio_min:     11'd640,
                       saw_balance_pct:    7'd75};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SWING_FLOOR: r_cfg.swing_floor        <= i_cfg_data[7:0];
                CFG_REGULAR_MIN: r_cfg.regular_pct_min    <= i_cfg_data[6:0];
                CFG_TWO_LEVEL:   r_cfg.two_level_pct_min  <= i_cfg_data[6:0];
                CFG_DUTY_LOW:    r_cfg.duty_low_permille  <= i_cfg_data[9:0];
                CFG_DUTY_HIGH:   r_cfg.duty_high_permille <= i_cfg_data[9:0];
                CFG_SQUARE_MIN:  r_cfg.square_ratio_min   <= i_cfg_data;
                CFG_SINE_MIN:    r_cfg.sine_ratio_min     <= i_cfg_data;
                CFG_SAW_BALANCE: r_cfg.saw_balance_pct    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic                   fr_ready, fr_valid, rt_ready, rt_valid, bk_ready;
    logic [RAD_W-1:0]       fr_rad;
    logic [SAMPLE_BITS-1:0] fr_vpp, rt_vpp;
    t_flags                 fr_flags, rt_flags;
    logic [CENTI_W-1:0]     rt_ac;
    logic [SIDE_W-1:0]      rt_side;

    assign o_stall = !fr_ready;

    wtc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_valid),
        .o_ready           (fr_ready),
        .i_top_level       (i_top_level),
        .i_base_level      (i_base_level),
        .i_frequency_found (i_frequency_found),
        .i_period_count    (i_period_count),
        .i_regular_pct     (i_regular_pct),
        .i_two_level_pct   (i_two_level_pct),
        .i_duty_permille   (i_duty_permille),
        .i_rms_centi       (i_rms_centi),
        .i_mean_centi      (i_mean_centi),
        .i_rising_samples  (i_rising_samples),
        .i_falling_samples (i_falling_samples),
        .o_valid           (fr_valid),
        .i_ready           (rt_ready),
        .o_rad             (fr_rad),
        .o_vpp             (fr_vpp),
        .o_flags           (fr_flags)
    );

    // Carry swing and decision flags alongside the root.
    wtc_root #(
        .SIDE_W (SIDE_W)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (rt_ready),
        .i_rad   (fr_rad),
        .i_side  ({fr_vpp, fr_flags}),
        .o_valid (rt_valid),
        .i_ready (bk_ready),
        .o_root  (rt_ac),
        .o_side  (rt_side)
    );

    assign rt_vpp   = rt_side[SIDE_W-1:FLAGS_W];
    assign rt_flags = t_flags'(rt_side[FLAGS_W-1:0]);

    wtc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (rt_valid),
        .o_ready       (bk_ready),
        .i_ac          (rt_ac),
        .i_vpp         (rt_vpp),
        .i_flags       (rt_flags),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_signal_type (o_signal_type)
    );

endmodule

// ===== hw/rtl/wtc_front.sv =====
// Front stages: swing, period, duty tests, squares and slope balance.
// Depends on wtc_pkg.
module wtc_front
    import wtc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SAMPLE_BITS-1:0]   i_top_level,
    input  logic [SAMPLE_BITS-1:0]   i_base_level,
    input  logic                     i_frequency_found,
    input  logic [COUNT_BITS-1:0]    i_period_count,
    input  logic [PCT_W-1:0]         i_regular_pct,
    input  logic [PCT_W-1:0]         i_two_level_pct,
    input  logic signed [DUTY_W-1:0] i_duty_permille,
    input  logic [CENTI_W-1:0]       i_rms_centi,
    input  logic [CENTI_W-1:0]       i_mean_centi,
    input  logic [COUNT_BITS-1:0]    i_rising_samples,
    input  logic [COUNT_BITS-1:0]    i_falling_samples,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [RAD_W-1:0]         o_rad,
    output logic [SAMPLE_BITS-1:0]   o_vpp,
    output t_flags                   o_flags
);

    localparam int MW = COUNT_BITS + 9;

    // stage 1
    logic                   r1_v;
    logic [SAMPLE_BITS-1:0] r1_vpp;
    t_flags                 r1_flags;
    logic [RAD_W-1:0]       r1_rms2, r1_mean2;
    logic [COUNT_BITS-1:0]  r1_up;
    logic [COUNT_BITS:0]    r1_moving;
    // stage 2
    logic                   r2_v;
    logic [SAMPLE_BITS-1:0] r2_vpp;
    t_flags                 r2_flags;
    logic [RAD_W-1:0]       r2_ac2;
    logic [MW-1:0]          r2_upx, r2_hi, r2_lo;
    logic                   r2_lo_en, r2_moving_nz;
    // stage 3
    logic                   r3_v;
    logic [SAMPLE_BITS-1:0] r3_vpp;
    t_flags                 r3_flags;
    logic [RAD_W-1:0]       r3_ac2;

    logic ld1, ld2, ld3;
    assign ld3     = !r3_v || i_ready;
    assign ld2     = !r2_v || ld3;
    assign ld1     = !r1_v || ld2;
    assign o_ready = ld1;

    logic signed [SAMPLE_BITS:0] n_vpp;
    logic   dc, irr, duty_hit;
    t_flags n_flags;

    always_comb begin
        n_vpp = $signed({1'b0, i_top_level}) - $signed({1'b0, i_base_level});
        dc    = n_vpp[SAMPLE_BITS]
             || (n_vpp[SAMPLE_BITS-1:0] < SAMPLE_BITS'(i_cfg.swing_floor));
        irr   = (i_period_count >= COUNT_BITS'(MIN_PERIODS))
             && (i_regular_pct < i_cfg.regular_pct_min);
        duty_hit = !i_duty_permille[DUTY_W-1]
             && ((i_duty_permille[9:0] < i_cfg.duty_low_permille)
              || (i_duty_permille[9:0] > i_cfg.duty_high_permille));
        n_flags = '{early: 1'b1, saw: 1'b0, etype: WAVE_DC};
        priority if (dc) begin
            n_flags.etype = WAVE_DC;
        end else if (!i_frequency_found) begin
            n_flags.etype = WAVE_NOISE;
        end else if (irr) begin
            n_flags.etype = (i_two_level_pct >= i_cfg.two_level_pct_min) ? WAVE_PULSE
                                                                          : WAVE_NOISE;
        end else if (duty_hit) begin
            n_flags.etype = WAVE_PULSE;
        end else begin
            n_flags.early = 1'b0;
        end
    end

    logic saw_hit;
    assign saw_hit = r2_moving_nz && ((r2_upx >= r2_hi) || (r2_lo_en && (r2_upx < r2_lo)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (ld1) r1_v <= i_valid;
            if (ld2) r2_v <= r1_v;
            if (ld3) r3_v <= r2_v;
        end
        if (ld1) begin
            r1_vpp    <= n_vpp[SAMPLE_BITS-1:0];
            r1_flags  <= n_flags;
            r1_rms2   <= RAD_W'(i_rms_centi * i_rms_centi);
            r1_mean2  <= RAD_W'(i_mean_centi * i_mean_centi);
            r1_up     <= i_rising_samples;
            r1_moving <= {1'b0, i_rising_samples} + {1'b0, i_falling_samples};
        end
        if (ld2) begin
            r2_vpp       <= r1_vpp;
            r2_flags     <= r1_flags;
            // clamp a negative AC power to zero
            r2_ac2       <= (r1_rms2 > r1_mean2) ? r1_rms2 - r1_mean2 : '0;
            r2_upx       <= MW'(r1_up * 7'd100);
            r2_hi        <= MW'(({1'b0, i_cfg.saw_balance_pct} + 8'd1) * r1_moving);
            r2_lo        <= MW'((7'(PCT_FULL) - i_cfg.saw_balance_pct) * r1_moving);
            r2_lo_en     <= (i_cfg.saw_balance_pct <= 7'(PCT_FULL));
            r2_moving_nz <= (r1_moving != '0);
        end
        if (ld3) begin
            r3_vpp       <= r2_vpp;
            r3_flags     <= '{early: r2_flags.early, saw: saw_hit, etype: r2_flags.etype};
            r3_ac2       <= r2_ac2;
        end
    end

    assign o_valid = r3_v;
    assign o_rad   = r3_ac2;
    assign o_vpp   = r3_vpp;
    assign o_flags = r3_flags;

endmodule

// ===== hw/rtl/wtc_root.sv =====
// Pipelined floor square root, one result bit per stage, side data alongside.
// Depends on wtc_pkg.
module wtc_root
    import wtc_pkg::*;
#(
    parameter int SIDE_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [RAD_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CENTI_W-1:0] o_root,
    output logic [SIDE_W-1:0]  o_side
);

    logic [ROOT_STEPS-1:0] r_v;
    logic [ROOT_STEPS:0]   rdy;
    logic [RAD_W-1:0]      r_rad  [ROOT_STEPS];
    logic [REM_W-1:0]      r_rem  [ROOT_STEPS];
    logic [CENTI_W-1:0]    r_root [ROOT_STEPS];
    logic [SIDE_W-1:0]     r_side [ROOT_STEPS];

    assign rdy[ROOT_STEPS] = i_ready;
    assign o_ready         = rdy[0];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        logic               v_in;
        logic [RAD_W-1:0]   rad_in;
        logic [REM_W-1:0]   rem_in, n_rem, trial;
        logic [CENTI_W-1:0] root_in;
        logic [SIDE_W-1:0]  side_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        assign rdy[k] = !r_v[k] || rdy[k+1];
        assign n_rem  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= v_in;
            end
            if (rdy[k]) begin
                r_rad[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                r_side[k] <= side_in;
                if (n_rem >= trial) begin
                    r_rem[k]  <= n_rem - trial;
                    r_root[k] <= {root_in[CENTI_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= {root_in[CENTI_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_STEPS-1];
    assign o_root  = r_root[ROOT_STEPS-1];
    assign o_side  = r_side[ROOT_STEPS-1];

endmodule

// ===== hw/rtl/wtc_back.sv =====
// Back stages: ratio thresholds by cross-multiplication, final choice, output register.
// Depends on wtc_pkg.
module wtc_back
    import wtc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [CENTI_W-1:0]     i_ac,
    input  logic [SAMPLE_BITS-1:0] i_vpp,
    input  t_flags                 i_flags,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [2:0]             o_signal_type
);

    localparam int PW = (CENTI_W + 5 > SAMPLE_BITS + 12) ? CENTI_W + 5 : SAMPLE_BITS + 12;

    logic          r1_v, r2_v;
    t_flags        r1_flags;
    logic [PW-1:0] r1_ac20, r1_sq, r1_si;
    t_wave         r2_type, n_type;
    logic          ld1, ld2;

    assign ld2     = !r2_v || !i_stall;
    assign ld1     = !r1_v || ld2;
    assign o_ready = ld1;

    // ratio > S  <=>  20*ac >= (S+1)*vpp ; ratio >= T  <=>  20*ac >= T*vpp
    always_comb begin
        priority if (r1_flags.early) begin
            n_type = r1_flags.etype;
        end else if (r1_ac20 >= r1_sq) begin
            n_type = WAVE_SQUARE;
        end else if (r1_flags.saw) begin
            n_type = WAVE_SAW;
        end else if (r1_ac20 >= r1_si) begin
            n_type = WAVE_SINE;
        end else begin
            n_type = WAVE_TRIANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (ld1) r1_v <= i_valid;
            if (ld2) r2_v <= r1_v;
        end
        if (ld1) begin
            r1_flags <= i_flags;
            r1_ac20  <= PW'(i_ac * 5'(RATIO_MUL));
            r1_sq    <= PW'(({1'b0, i_cfg.square_ratio_min} + 12'd1) * i_vpp);
            r1_si    <= PW'(i_cfg.sine_ratio_min * i_vpp);
        end
        if (ld2) begin
            r2_type <= n_type;
        end
    end

    assign o_valid       = r2_v;
    assign o_signal_type = r2_type;

endmodule

// ===== verif/tb_waveform_type_classifier.sv =====
// Self-checking testbench for the waveform type classifier.
// Depends on wtc_pkg and waveform_type_classifier; predicts each waveform
// type from its own copy of the thresholds and scores results in order.
`timescale 1ns / 100ps

module tb_waveform_type_classifier;
    import wtc_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int CB = COUNT_BITS_DEF;
    localparam int LATENCY = 20;

    // One measurement record as driven on the input ports.
    typedef struct {
        logic [SB-1:0]            top;
        logic [SB-1:0]            base;
        logic                     freq;
        logic [CB-1:0]            periods;
        logic [PCT_W-1:0]         reg_pct;
        logic [PCT_W-1:0]         lvl_pct;
        logic signed [DUTY_W-1:0] duty;
        logic [CENTI_W-1:0]       rms;
        logic [CENTI_W-1:0]       mean;
        logic [CB-1:0]            up;
        logic [CB-1:0]            down;
    } t_record;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [SB-1:0]            i_top_level = '0;
    logic [SB-1:0]            i_base_level = '0;
    logic                     i_frequency_found = 1'b0;
    logic [CB-1:0]            i_period_count = '0;
    logic [PCT_W-1:0]         i_regular_pct = '0;
    logic [PCT_W-1:0]         i_two_level_pct = '0;
    logic signed [DUTY_W-1:0] i_duty_permille = '0;
    logic [CENTI_W-1:0]       i_rms_centi = '0;
    logic [CENTI_W-1:0]       i_mean_centi = '0;
    logic [CB-1:0]            i_rising_samples = '0;
    logic [CB-1:0]            i_falling_samples = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [2:0]               o_signal_type;

    waveform_type_classifier dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state: thresholds as the block holds them.
    t_cfg  thresholds;
    t_wave expected_types[$];
    int    errors = 0;
    bit    quiet = 1'b0;       // no random gaps on either side while set
    int    stall_left = 0;     // receiver wait after the last transfer
    int    hold_off = 0;       // long receiver hold-off, pressure test

    // Floor square root, one result bit per pass from the top.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic t_wave classify_record(t_record r, t_cfg c);
        longint vpp;
        longint unsigned rms2;
        longint unsigned mean2;
        longint unsigned ac;
        longint unsigned ratio;
        longint unsigned moving;
        longint rising;
        longint bal;
        longint duty;
        vpp = longint'(r.top) - longint'(r.base);
        duty = longint'(r.duty);
        if (vpp < longint'(c.swing_floor)) return WAVE_DC;
        if (!r.freq) return WAVE_NOISE;
        if (r.periods >= MIN_PERIODS && r.reg_pct < c.regular_pct_min)
            return (r.lvl_pct >= c.two_level_pct_min) ? WAVE_PULSE : WAVE_NOISE;
        if (duty >= 0 && (duty < longint'(c.duty_low_permille) ||
                          duty > longint'(c.duty_high_permille)))
            return WAVE_PULSE;
        rms2 = longint'(r.rms) * longint'(r.rms);
        mean2 = longint'(r.mean) * longint'(r.mean);
        // Clamp a negative AC power to zero.
        ac = isqrt((rms2 > mean2) ? rms2 - mean2 : 0);
        if (vpp == 0) ratio = '1;
        else ratio = ac * 2000 / (longint'(vpp) * 100);
        if (ratio > c.square_ratio_min) return WAVE_SQUARE;
        moving = longint'(r.up) + longint'(r.down);
        if (moving > 0) begin
            rising = longint'(longint'(r.up) * 100 / moving);
            bal = longint'(c.saw_balance_pct);
            if (rising > bal || rising < 100 - bal) return WAVE_SAW;
        end
        return (ratio >= c.sine_ratio_min) ? WAVE_SINE : WAVE_TRIANGLE;
    endfunction

    // Hold until every expected result is in, then let the pipe drain.
    task automatic wait_idle();
        while (expected_types.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_threshold(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SWING_FLOOR: thresholds.swing_floor        = data[7:0];
            CFG_REGULAR_MIN: thresholds.regular_pct_min    = data[6:0];
            CFG_TWO_LEVEL:   thresholds.two_level_pct_min  = data[6:0];
            CFG_DUTY_LOW:    thresholds.duty_low_permille  = data[9:0];
            CFG_DUTY_HIGH:   thresholds.duty_high_permille = data[9:0];
            CFG_SQUARE_MIN:  thresholds.square_ratio_min   = data[10:0];
            CFG_SINE_MIN:    thresholds.sine_ratio_min     = data[10:0];
            CFG_SAW_BALANCE: thresholds.saw_balance_pct    = data[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_defaults();
        write_threshold(CFG_SWING_FLOOR, 6);
        write_threshold(CFG_REGULAR_MIN, 60);
        write_threshold(CFG_TWO_LEVEL, 65);
        write_threshold(CFG_DUTY_LOW, 400);
        write_threshold(CFG_DUTY_HIGH, 600);
        write_threshold(CFG_SQUARE_MIN, 850);
        write_threshold(CFG_SINE_MIN, 640);
        write_threshold(CFG_SAW_BALANCE, 75);
    endtask

    // Offer one record, after a random gap unless quiet; record the prediction on transfer.
    task automatic send_record(t_record r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_top_level       <= r.top;
        i_base_level      <= r.base;
        i_frequency_found <= r.freq;
        i_period_count    <= r.periods;
        i_regular_pct     <= r.reg_pct;
        i_two_level_pct   <= r.lvl_pct;
        i_duty_permille   <= r.duty;
        i_rms_centi       <= r.rms;
        i_mean_centi      <= r.mean;
        i_rising_samples  <= r.up;
        i_falling_samples <= r.down;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_types.push_back(classify_record(r, thresholds));
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
    endtask

    // Build a record from explicit fields, for the directed cases.
    function automatic t_record mk(int top, int base, int freq, int periods, int reg_pct,
                                   int lvl_pct, int duty, int rms, int mean,
                                   int up, int down);
        t_record r;
        r.top = top; r.base = base; r.freq = freq; r.periods = periods;
        r.reg_pct = reg_pct; r.lvl_pct = lvl_pct; r.duty = duty;
        r.rms = rms; r.mean = mean; r.up = up; r.down = down;
        return r;
    endfunction

    // Mostly plausible captures so the deeper branches get exercised;
    // the rest is raw noise over the full field ranges.
    function automatic t_record random_record();
        t_record r;
        int vpp;
        if ($urandom_range(0, 9) < 2) begin
            r.top = $urandom; r.base = $urandom; r.freq = $urandom;
            r.periods = $urandom; r.reg_pct = $urandom; r.lvl_pct = $urandom;
            r.duty = $urandom; r.rms = $urandom; r.mean = $urandom;
            r.up = $urandom; r.down = $urandom;
            return r;
        end
        r.base = $urandom_range(0, 200);
        r.top = $urandom_range(r.base, 255);
        vpp = r.top - r.base;
        r.freq = ($urandom_range(0, 19) != 0);
        r.periods = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : $urandom;
        r.reg_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                : $urandom_range(60, 100);
        r.lvl_pct = $urandom_range(0, 100);
        case ($urandom_range(0, 5))
            0: r.duty = -$urandom_range(1, 1024);
            1: r.duty = $urandom_range(0, 1000);
            default: r.duty = $urandom_range(380, 620);
        endcase
        r.mean = $urandom_range(0, 25500);
        r.rms = (r.mean + $urandom_range(0, vpp * 60 + 1) > 32767) ? 32767
                : r.mean + $urandom_range(0, vpp * 60 + 1);
        if ($urandom_range(0, 9) == 0) r.rms = $urandom_range(0, r.mean);
        r.up = $urandom_range(0, 3000);
        r.down = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3000)
                                             : r.up + $urandom_range(0, 600) - 300;
        if ($urandom_range(0, 19) == 0) begin
            r.up = 0; r.down = 0;
        end
        return r;
    endfunction

    // Receiver: wait a random count after each transfer, or hold off.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_stall  <= 1'b1;
            hold_off <= hold_off - 1;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Score every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_types.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $realtime, o_signal_type);
                errors++;
            end else begin
                if (o_signal_type !== expected_types[0]) begin
                    $display("%0t: signal_type expected %0d, actual %0d",
                             $realtime, expected_types[0], o_signal_type);
                    errors++;
                end
                void'(expected_types.pop_front());
            end
            stall_left <= quiet ? 0 : $urandom_range(0, 13);
        end
    end

    // Directed records at the reset thresholds: each branch of the tree.
    task automatic test_decision_tree();
        send_record(mk(255, 0, 1, 65535, 100, 0, 500, 25500, 0, 10, 10));
        send_record(mk(0, 255, 1, 10, 100, 0, 500, 9000, 100, 10, 10));   // base above top
        send_record(mk(10, 5, 1, 10, 100, 0, 500, 9000, 100, 10, 10));    // swing just below
        send_record(mk(100, 0, 0, 10, 100, 0, 500, 9000, 100, 10, 10));   // no frequency
        send_record(mk(100, 0, 1, 3, 59, 65, 500, 9000, 100, 10, 10));    // irregular pulse
        send_record(mk(100, 0, 1, 3, 59, 64, 500, 9000, 100, 10, 10));    // irregular noise
        send_record(mk(100, 0, 1, 2, 0, 0, 500, 3000, 0, 10, 10));        // too few periods
        send_record(mk(100, 0, 1, 10, 100, 0, 399, 3000, 0, 10, 10));     // duty low
        send_record(mk(100, 0, 1, 10, 100, 0, 601, 3000, 0, 10, 10));     // duty high
        send_record(mk(100, 0, 1, 10, 100, 0, -1, 3540, 0, 10, 10));      // unmeasured duty
        send_record(mk(100, 0, 1, 10, 100, 0, -1024, 3540, 0, 10, 10));
        send_record(mk(100, 0, 1, 10, 100, 0, 400, 4300, 0, 10, 10));     // square
        send_record(mk(100, 0, 1, 10, 100, 0, 600, 3540, 0, 80, 20));     // rising saw
        send_record(mk(100, 0, 1, 10, 100, 0, 500, 3540, 0, 20, 80));     // falling saw
        send_record(mk(100, 0, 1, 10, 100, 0, 500, 3540, 0, 75, 25));     // balance edge
        send_record(mk(100, 0, 1, 10, 100, 0, 500, 3540, 0, 0, 0));       // no moving samples
        send_record(mk(100, 0, 1, 10, 100, 0, 500, 2900, 0, 10, 10));     // triangle
        send_record(mk(100, 0, 1, 10, 100, 0, 500, 100, 9000, 10, 10));   // mean above rms
        send_record(mk(255, 0, 1, 0, 0, 100, 1000, 32767, 32767, 65535, 65535));
        send_record(mk(6, 0, 1, 65535, 127, 127, 1023, 32767, 0, 65535, 0));
        end_burst();
    endtask

    // Extreme and random thresholds, including zero swing and a dead balance.
    task automatic test_threshold_extremes();
        wait_idle();
        write_threshold(CFG_SWING_FLOOR, 0);
        write_threshold(CFG_REGULAR_MIN, 0);
        write_threshold(CFG_TWO_LEVEL, 0);
        write_threshold(CFG_DUTY_LOW, 0);
        write_threshold(CFG_DUTY_HIGH, 1023);
        write_threshold(CFG_SQUARE_MIN, 2047);
        write_threshold(CFG_SINE_MIN, 0);
        write_threshold(CFG_SAW_BALANCE, 127);
        send_record(mk(50, 50, 1, 10, 100, 0, 500, 3000, 0, 10, 10));     // zero swing
        send_record(mk(50, 50, 1, 10, 100, 0, 500, 0, 0, 99, 1));
        send_record(mk(200, 0, 1, 10, 0, 0, 0, 32767, 0, 99, 1));
        for (int k = 0; k < 40; k++) send_record(random_record());
        end_burst();
        wait_idle();
        write_threshold(CFG_SWING_FLOOR, 255);
        write_threshold(CFG_REGULAR_MIN, 100);
        write_threshold(CFG_TWO_LEVEL, 100);
        write_threshold(CFG_DUTY_LOW, 1000);
        write_threshold(CFG_DUTY_HIGH, 0);
        write_threshold(CFG_SQUARE_MIN, 0);
        write_threshold(CFG_SINE_MIN, 2000);
        write_threshold(CFG_SAW_BALANCE, 50);
        send_record(mk(255, 0, 1, 10, 100, 0, -1, 100, 0, 10, 10));
        for (int k = 0; k < 30; k++) send_record(random_record());
        end_burst();
        wait_idle();
        write_threshold(CFG_SWING_FLOOR, 1);
        for (int k = 0; k < 30; k++) send_record(random_record());
        end_burst();
    endtask

    // Defaults, then random threshold sets, with a full random data word for the square minimum.
    task automatic test_random_records();
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            if (p == 0) begin
                load_defaults();
            end else begin
                write_threshold(CFG_SWING_FLOOR, $urandom_range(0, 40));
                write_threshold(CFG_REGULAR_MIN, $urandom_range(0, 100));
                write_threshold(CFG_TWO_LEVEL, $urandom_range(0, 100));
                write_threshold(CFG_DUTY_LOW, $urandom_range(0, 500));
                write_threshold(CFG_DUTY_HIGH, $urandom_range(500, 1000));
                write_threshold(CFG_SQUARE_MIN, $urandom);
                write_threshold(CFG_SINE_MIN, $urandom_range(0, 1200));
                write_threshold(CFG_SAW_BALANCE, $urandom_range(50, 100));
            end
            quiet = (p == 3);
            for (int k = 0; k < 45; k++) send_record(random_record());
            end_burst();
        end
        quiet = 1'b0;
    endtask

    // Hold off the receiver while records stream in back to back.
    task automatic test_backpressure();
        wait_idle();
        load_defaults();
        quiet = 1'b1;
        @(negedge i_clk);
        hold_off = 200;
        for (int k = 0; k < 60; k++) send_record(random_record());
        end_burst();
        quiet = 1'b0;
    endtask

    initial begin
        thresholds = '{swing_floor: 6, regular_pct_min: 60, two_level_pct_min: 65,
                       duty_low_permille: 400, duty_high_permille: 600,
                       square_ratio_min: 850, sine_ratio_min: 640,
                       saw_balance_pct: 75};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_decision_tree();
        test_threshold_extremes();
        test_random_records();
        test_backpressure();
        wait_idle();
        errors += expected_types.size();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
